>>> rtl/bdrd_pkg.sv
// Package: shared types, codes and calendar helpers for the business-day return date block.
package bdrd_pkg;

	localparam int unsigned MAX_YEAR = 9999;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BAD_DATE = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [4:0]  start_day;
		logic [3:0]  start_month;
		logic [13:0] start_year;
		logic [11:0] working_days;
	} item_t;

	typedef struct packed {
		logic [4:0]  return_day;
		logic [3:0]  return_month;
		logic [13:0] return_year;
		logic [2:0]  return_weekday;
		status_t     status;
	} result_t;

	// Classified job handed from the front end to the day walker.
	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [11:0] left;
		logic [2:0]  wd;
		logic [1:0]  r4;
		logic [6:0]  r100;
		logic [8:0]  r400;
		logic        bad;
	} job_t;

	localparam logic [2:0] WD_SUN = 3'd0;
	localparam logic [2:0] WD_SAT = 3'd6;

	function automatic logic is_leap(input logic [1:0] r4, input logic [6:0] r100,
			input logic [8:0] r400);
		return ((r4 == 2'd0) && (r100 != 7'd0)) || (r400 == 9'd0);
	endfunction

	function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

>>> rtl/business_day_return_date.sv
// Top level: business-day return date calculator.
//
// Takes a Gregorian start date and a count of working days and returns the
// date on which the traveller is back at work, with its weekday (0 Sunday
// through 6 Saturday). A start on a weekend is first moved to the next
// Monday, then each weekday left behind uses up one working day, and a
// weekend reached at the end is skipped as well. Leap years follow the
// 4/100/400 rules. Status reads 1 for an invalid start date (month outside
// 1..12, year outside 1..9999, day 0 or past the month's end) and 2 when the
// walk would pass 31 December 9999; date and weekday fields are then zero.
// Both sides look like a queue: write an item with push while full is low,
// read a result while empty is low and take it with pop. The front end
// checks the date and derives the weekday in its divide, sum and modulo
// states and passes the job through a two-entry queue to the day walker,
// which advances one calendar day per cycle while it walks. The walker sets
// the sustained rate, while the front end keeps accepting and classifying
// the next items and a finished result waits in its own output register.
module business_day_return_date import bdrd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    push,
	output logic    full,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	job_t fq_wr_job, fq_rd_job;
	logic fq_wr, fq_full, fq_valid, fq_rd;

	bdrd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.push     (push),
		.full     (full),
		.job      (fq_wr_job),
		.job_push (fq_wr),
		.job_full (fq_full)
	);

	bdrd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_job (fq_wr_job),
		.wr     (fq_wr),
		.full   (fq_full),
		.rd_job (fq_rd_job),
		.valid  (fq_valid),
		.rd     (fq_rd)
	);

	bdrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (fq_rd_job),
		.job_valid (fq_valid),
		.job_take  (fq_rd),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

>>> rtl/bdrd_front.sv
// Front end: accept an item, check the date, work out its weekday and leap-year residues.
module bdrd_front import bdrd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t item,
	input  logic  push,
	output logic  full,
	output job_t  job,
	output logic  job_push,
	input  logic  job_full
);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_SUM, F_MOD} fstate_t;

	fstate_t     state_q;
	item_t       in_q;
	logic [7:0]  q100_q;
	logic [14:0] s_q;
	logic [1:0]  r4_q;
	logic [6:0]  r100_q;
	logic [8:0]  r400_q;
	logic        bad_q;

	// floor(31*mm/12) indexed by the calendar month
	function automatic logic [4:0] month_term(input logic [3:0] m);
		logic [4:0] t;
		case (m)
			4'd1:    t = 5'd28;
			4'd2:    t = 5'd31;
			4'd3:    t = 5'd2;
			4'd4:    t = 5'd5;
			4'd5:    t = 5'd7;
			4'd6:    t = 5'd10;
			4'd7:    t = 5'd12;
			4'd8:    t = 5'd15;
			4'd9:    t = 5'd18;
			4'd10:   t = 5'd20;
			4'd11:   t = 5'd23;
			4'd12:   t = 5'd25;
			default: t = 5'd0;
		endcase
		return t;
	endfunction

	// year / 100 by reciprocal: 5243 / 2^19
	logic [26:0] div_prod;
	assign div_prod = 27'(in_q.start_year) * 27'd5243;

	// residues and weekday sum
	logic [13:0] r100_w14, r400_w14;
	logic [6:0]  r100_w;
	logic [8:0]  r400_w;
	logic [5:0]  q400_w;
	logic        leap_w, a_w, bad_w;
	logic [4:0]  dim_w;
	logic [13:0] yy_w;
	logic [11:0] yy4_w;
	logic [7:0]  yy100_w;
	logic [5:0]  yy400_w;
	logic [15:0] s_w;

	always_comb begin
		q400_w   = q100_q[7:2];
		r100_w14 = in_q.start_year - 14'(q100_q) * 14'd100;
		r400_w14 = in_q.start_year - 14'(q400_w) * 14'd400;
		r100_w   = r100_w14[6:0];
		r400_w   = r400_w14[8:0];
		leap_w   = is_leap(in_q.start_year[1:0], r100_w, r400_w);
		dim_w    = days_in(in_q.start_month, leap_w);
		bad_w    = (in_q.start_month == 4'd0) || (in_q.start_month > 4'd12) ||
		           (in_q.start_year == 14'd0) || (in_q.start_year > 14'(MAX_YEAR)) ||
		           (in_q.start_day == 5'd0) || (in_q.start_day > dim_w);
		a_w      = (in_q.start_month <= 4'd2);
		yy_w     = in_q.start_year - 14'(a_w);
		yy4_w    = in_q.start_year[13:2] -
		           12'(a_w && (in_q.start_year[1:0] == 2'd0));
		yy100_w  = q100_q - 8'(a_w && (r100_w == 7'd0));
		yy400_w  = q400_w - 6'(a_w && (r400_w == 9'd0));
		s_w      = 16'(in_q.start_day) + 16'(yy_w) + 16'(yy4_w) + 16'(yy400_w) +
		           16'(month_term(in_q.start_month)) - 16'(yy100_w);
	end

	// sum mod 7 by reciprocal: 149797 / 2^20
	logic [32:0] mod_prod;
	logic [12:0] q7_w;
	logic [14:0] wd_w15;
	assign mod_prod = 33'(s_q) * 33'd149797;
	assign q7_w     = mod_prod[32:20];
	assign wd_w15   = s_q - 15'(q7_w) * 15'd7;

	always_comb begin
		job.day   = in_q.start_day;
		job.month = in_q.start_month;
		job.year  = in_q.start_year;
		job.left  = in_q.working_days;
		job.wd    = wd_w15[2:0];
		job.r4    = r4_q;
		job.r100  = r100_q;
		job.r400  = r400_q;
		job.bad   = bad_q;
	end

	assign full     = (state_q != F_IDLE);
	assign job_push = (state_q == F_MOD) && !job_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (push) state_q <= F_DIV;
				end
				F_DIV:  state_q <= F_SUM;
				F_SUM:  state_q <= F_MOD;
				F_MOD: begin
					if (!job_full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) in_q <= item;
		if (state_q == F_DIV) q100_q <= div_prod[26:19];
		if (state_q == F_SUM) begin
			s_q    <= s_w[14:0];
			r4_q   <= in_q.start_year[1:0];
			r100_q <= r100_w;
			r400_q <= r400_w;
			bad_q  <= bad_w;
		end
	end

endmodule

>>> rtl/bdrd_queue.sv
// Two-entry job queue between the front end and the day walker.
module bdrd_queue import bdrd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t wr_job,
	input  logic wr,
	output logic full,
	output job_t rd_job,
	output logic valid,
	input  logic rd
);

	job_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full   = (count_q == 2'd2);
	assign valid  = (count_q != 2'd0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr && !full) wr_ptr_q <= !wr_ptr_q;
			if (rd && valid) rd_ptr_q <= !rd_ptr_q;
			case ({wr && !full, rd && valid})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

>>> rtl/bdrd_back.sv
// Day walker: step the calendar one day per cycle and hold the finished result.
module bdrd_back import bdrd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  job_t    job,
	input  logic    job_valid,
	output logic    job_take,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	typedef enum logic [2:0] {B_IDLE, B_SKIP1, B_COUNT, B_SKIP2, B_DONE} bstate_t;

	bstate_t     state_q;
	logic [4:0]  d_q;
	logic [3:0]  m_q;
	logic [13:0] y_q;
	logic [11:0] left_q;
	logic [2:0]  wd_q;
	logic [1:0]  r4_q;
	logic [6:0]  r100_q;
	logic [8:0]  r400_q;
	result_t     res_q;
	result_t     out_q;
	logic        out_valid_q;

	logic       weekend, at_end, ovf, out_free;
	logic [4:0] dim;

	always_comb begin
		weekend  = (wd_q == WD_SUN) || (wd_q == WD_SAT);
		dim      = days_in(m_q, is_leap(r4_q, r100_q, r400_q));
		at_end   = (d_q >= dim);
		ovf      = at_end && (m_q == 4'd12) && (y_q >= 14'(MAX_YEAR));
		out_free = !out_valid_q || pop;
	end

	assign job_take = (state_q == B_IDLE) && job_valid;
	assign result   = out_q;
	assign empty    = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == B_DONE && out_free) out_valid_q <= 1'b1;
			else if (pop && out_valid_q)        out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) state_q <= job.bad ? B_DONE : B_SKIP1;
				end
				B_SKIP1: begin
					if (!weekend) state_q <= B_COUNT;
					else if (ovf) state_q <= B_DONE;
				end
				B_COUNT: begin
					if (left_q == 12'd0) state_q <= B_SKIP2;
					else if (ovf)        state_q <= B_DONE;
				end
				B_SKIP2: begin
					if (!weekend || ovf) state_q <= B_DONE;
				end
				B_DONE: begin
					if (out_free) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	logic do_step;
	always_comb begin
		case (state_q)
			B_SKIP1, B_SKIP2: do_step = weekend && !ovf;
			B_COUNT:          do_step = (left_q != 12'd0) && !ovf;
			default:          do_step = 1'b0;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && job_valid) begin
			d_q    <= job.day;
			m_q    <= job.month;
			y_q    <= job.year;
			left_q <= job.left;
			wd_q   <= job.wd;
			r4_q   <= job.r4;
			r100_q <= job.r100;
			r400_q <= job.r400;
			res_q  <= '{return_day: 5'd0, return_month: 4'd0, return_year: 14'd0,
			            return_weekday: 3'd0, status: STATUS_BAD_DATE};
		end
		if (do_step) begin
			if (at_end) begin
				d_q <= 5'd1;
				if (m_q == 4'd12) begin
					m_q    <= 4'd1;
					y_q    <= y_q + 14'd1;
					r4_q   <= r4_q + 2'd1;
					r100_q <= (r100_q == 7'd99)  ? 7'd0 : r100_q + 7'd1;
					r400_q <= (r400_q == 9'd399) ? 9'd0 : r400_q + 9'd1;
				end else begin
					m_q <= m_q + 4'd1;
				end
			end else begin
				d_q <= d_q + 5'd1;
			end
			wd_q <= (wd_q == WD_SAT) ? WD_SUN : wd_q + 3'd1;
			if (state_q == B_COUNT && !weekend) left_q <= left_q - 12'd1;
		end
		// overflow: the next step would pass the last day of the last year
		if ((state_q == B_SKIP1 && weekend && ovf) ||
		    (state_q == B_COUNT && left_q != 12'd0 && ovf) ||
		    (state_q == B_SKIP2 && weekend && ovf)) begin
			res_q <= '{return_day: 5'd0, return_month: 4'd0, return_year: 14'd0,
			           return_weekday: 3'd0, status: STATUS_OVERFLOW};
		end
		if (state_q == B_SKIP2 && !weekend) begin
			res_q <= '{return_day: d_q, return_month: m_q, return_year: y_q,
			           return_weekday: wd_q, status: STATUS_OK};
		end
		if (state_q == B_DONE && out_free) out_q <= res_q;
	end

endmodule

>>> rtl/bdrd_checker.sv
// Checker: port-level properties of the business-day return date block, bound to the top level.
module bdrd_checker import bdrd_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input result_t result,
	input logic    empty,
	input logic    pop
);

	// a waiting result holds until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed or vanished before pop");

	// a failed transaction carries zero date fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status != STATUS_OK |->
		result.return_day == 5'd0 && result.return_month == 4'd0 &&
		result.return_year == 14'd0 && result.return_weekday == 3'd0)
		else $error("error result with nonzero date");

	// a good return date is a weekday with a plausible date
	a_ok_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status == STATUS_OK |->
		result.return_weekday != WD_SUN && result.return_weekday != WD_SAT &&
		result.return_weekday <= 3'd5 && result.return_day != 5'd0 &&
		result.return_month != 4'd0 && result.return_month <= 4'd12 &&
		result.return_year != 14'd0 && result.return_year <= 14'(MAX_YEAR))
		else $error("ok result is not a valid weekday date");

	// status only takes defined codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.status == STATUS_OK || result.status == STATUS_BAD_DATE ||
		result.status == STATUS_OVERFLOW)
		else $error("undefined status code");

endmodule

bind business_day_return_date bdrd_checker u_bdrd_checker (.*);
